[hw/rtl/assert_macros.svh]
// Assertion macros used by the ordered record list core.
// Every macro checks on the rising clock edge and is off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: assertion failed");

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

`endif

[hw/rtl/ordl_pkg.sv]
package ordl_pkg;

	// Default sizes of the list.
	localparam int CAPACITY_DFLT      = 16;
	localparam int KEY_WIDTH_DFLT     = 16;
	localparam int PAYLOAD_WIDTH_DFLT = 32;

	localparam int OPCODE_WIDTH = 3;
	localparam int STATUS_WIDTH = 3;

	typedef enum logic [OPCODE_WIDTH-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_SORT = 3'd2,
		OP_RM_HEAD  = 3'd3,
		OP_RM_TAIL  = 3'd4,
		OP_RM_KEY   = 3'd5,
		OP_RD_POS   = 3'd6,
		OP_RD_KEY   = 3'd7
	} opcode_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_BADPOS   = 3'd4
	} status_t;

endpackage

[hw/rtl/ordered_record_list_core.sv]
// Ordered record list: a bounded list of up to CAPACITY records, each a key
// and a payload word, kept in one RAM with position 1 at address 0. Every
// input transaction carries one operation (insert at head, tail or in key
// order, remove head, tail or by key, read by position or by key) and yields
// exactly one output transaction with a status, the record read (zero unless
// a read finds one), the entry count after the operation and an empty flag.
// The block handles one operation at a time and does not accept input while
// it works. Status-only answers and tail removal go straight to the result,
// a tail insert writes once and a read by position reads once; head inserts
// and head removals from a list of more than one entry shift it, and ordered
// inserts and key operations scan it first. The single RAM read port sets
// the pace: scans and shifts move one entry per cycle through it, and the
// scan up to an insert point and the shift back from the tail to it together
// visit every entry, the one at the insert point twice. A finished result
// waits in the output register while the next input transaction is taken;
// while the output register still holds an unaccepted result, the next
// operation waits in its final step. There is no clearing pass after reset;
// the data of entries beyond the count is never used.
`include "assert_macros.svh"

module ordered_record_list_core #(
	parameter int CAPACITY      = ordl_pkg::CAPACITY_DFLT,
	parameter int KEY_WIDTH     = ordl_pkg::KEY_WIDTH_DFLT,
	parameter int PAYLOAD_WIDTH = ordl_pkg::PAYLOAD_WIDTH_DFLT,
	localparam int CW    = $clog2(CAPACITY + 1),
	localparam int IN_W  = ordl_pkg::OPCODE_WIDTH + KEY_WIDTH + PAYLOAD_WIDTH + CW,
	localparam int S_W   = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W = ordl_pkg::STATUS_WIDTH + KEY_WIDTH + PAYLOAD_WIDTH + CW + 1,
	localparam int M_W   = ((OUT_W + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// Input transaction.
	input  logic           s_tvalid,
	output logic           s_tready,
	// Fields from bit 0 up: opcode, key, payload, position, zero padding.
	input  logic [S_W-1:0] s_tdata,
	// Output transaction.
	output logic           m_tvalid,
	input  logic           m_tready,
	// Fields from bit 0 up: status, key_read, payload_read, entry_total,
	// is_empty, zero padding.
	output logic [M_W-1:0] m_tdata
);

	import ordl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int RW = KEY_WIDTH + PAYLOAD_WIDTH;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_UP    = 7'b0000100,
		S_DOWN  = 7'b0001000,
		S_WRITE = 7'b0010000,
		S_READ  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                   state_q;
	opcode_t                  op_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	status_t                  status_q;
	logic [KEY_WIDTH-1:0]     rk_q;
	logic [PAYLOAD_WIDTH-1:0] rp_q;
	logic [CW-1:0]            count_q;
	// Walk pointer: the address presented to the RAM read port this cycle.
	logic [CW-1:0]            ptr_q;
	// Index of the entry whose data comes out of the RAM this cycle.
	logic [CW-1:0]            idx_q;
	// High when the RAM output holds the entry at idx_q.
	logic                     chk_q;
	// High while the shift walk still has reads to issue.
	logic                     iss_q;
	// Target index of an insert.
	logic [CW-1:0]            tgt_q;
	logic                     m_tvalid_q;
	logic [M_W-1:0]           m_tdata_q;

	// Unpacked input fields.
	opcode_t                  in_op;
	logic [KEY_WIDTH-1:0]     in_key;
	logic [PAYLOAD_WIDTH-1:0] in_pay;
	logic [CW-1:0]            in_pos;

	assign in_op  = opcode_t'(s_tdata[OPCODE_WIDTH-1:0]);
	assign in_key = s_tdata[OPCODE_WIDTH +: KEY_WIDTH];
	assign in_pay = s_tdata[OPCODE_WIDTH + KEY_WIDTH +: PAYLOAD_WIDTH];
	assign in_pos = s_tdata[OPCODE_WIDTH + KEY_WIDTH + PAYLOAD_WIDTH +: CW];

	// RAM ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;

	ordl_ram #(
		.WIDTH(RW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	logic [KEY_WIDTH-1:0]     rd_key;
	logic [PAYLOAD_WIDTH-1:0] rd_pay;
	logic                     full;
	logic                     last_idx;
	logic                     hit;

	assign rd_key   = ram_rdata[RW-1:PAYLOAD_WIDTH];
	assign rd_pay   = ram_rdata[PAYLOAD_WIDTH-1:0];
	assign full     = (count_q == CW'(CAPACITY));
	assign last_idx = (idx_q == count_q - CW'(1));
	// The ordered insert stops at the first key that is not smaller; the
	// key searches stop at the first equal key.
	assign hit      = (op_q == OP_INS_SORT) ? (rd_key >= key_q) : (rd_key == key_q);

	// Write port: shifts move the entry just read one place up or down,
	// and the final write of an insert stores the new record.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tgt_q[AW-1:0];
		ram_wdata = {key_q, pay_q};
		case (state_q)
			S_UP: begin
				ram_we    = chk_q;
				ram_waddr = idx_q[AW-1:0] + AW'(1);
				ram_wdata = ram_rdata;
			end
			S_DOWN: begin
				ram_we    = chk_q;
				ram_waddr = idx_q[AW-1:0] - AW'(1);
				ram_wdata = ram_rdata;
			end
			S_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_INS_HEAD;
			key_q      <= '0;
			pay_q      <= '0;
			status_q   <= STAT_OK;
			rk_q       <= '0;
			rp_q       <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			idx_q      <= '0;
			chk_q      <= 1'b0;
			iss_q      <= 1'b0;
			tgt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					chk_q <= 1'b0;
					iss_q <= 1'b0;
					if (s_tvalid) begin
						op_q     <= in_op;
						key_q    <= in_key;
						pay_q    <= in_pay;
						status_q <= STAT_OK;
						rk_q     <= '0;
						rp_q     <= '0;
						ptr_q    <= '0;
						case (in_op)
							OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORT: begin
								if (full) begin
									status_q <= STAT_FULL;
									state_q  <= S_DONE;
								end else if (in_op == OP_INS_TAIL || count_q == '0) begin
									tgt_q   <= (in_op == OP_INS_TAIL) ? count_q : '0;
									state_q <= S_WRITE;
								end else if (in_op == OP_INS_HEAD) begin
									// Shift every entry up by one, from the tail down.
									tgt_q   <= '0;
									ptr_q   <= count_q - CW'(1);
									iss_q   <= 1'b1;
									state_q <= S_UP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_RM_HEAD: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= S_DONE;
								end else if (count_q == CW'(1)) begin
									count_q <= '0;
									state_q <= S_DONE;
								end else begin
									ptr_q   <= CW'(1);
									iss_q   <= 1'b1;
									state_q <= S_DOWN;
								end
							end
							OP_RM_TAIL: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									count_q <= count_q - CW'(1);
								end
								state_q <= S_DONE;
							end
							OP_RM_KEY, OP_RD_KEY: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_RD_POS: begin
								if (in_pos == '0) begin
									status_q <= STAT_BADPOS;
									state_q  <= S_DONE;
								end else if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= S_DONE;
								end else if (in_pos > count_q) begin
									status_q <= STAT_BADPOS;
									state_q  <= S_DONE;
								end else begin
									ptr_q   <= in_pos - CW'(1);
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_SCAN: begin
					// Read one entry per cycle and compare the one that arrives.
					ptr_q <= ptr_q + CW'(1);
					idx_q <= ptr_q;
					chk_q <= (ptr_q < count_q);
					if (chk_q && (hit || last_idx)) begin
						chk_q <= 1'b0;
						case (op_q)
							OP_INS_SORT: begin
								if (!hit) begin
									tgt_q   <= count_q;
									state_q <= S_WRITE;
								end else begin
									tgt_q   <= idx_q;
									ptr_q   <= count_q - CW'(1);
									iss_q   <= 1'b1;
									state_q <= S_UP;
								end
							end
							OP_RM_KEY: begin
								if (!hit) begin
									status_q <= STAT_NOTFOUND;
									state_q  <= S_DONE;
								end else if (last_idx) begin
									count_q <= count_q - CW'(1);
									state_q <= S_DONE;
								end else begin
									ptr_q   <= idx_q + CW'(1);
									iss_q   <= 1'b1;
									state_q <= S_DOWN;
								end
							end
							default: begin
								if (!hit) begin
									status_q <= STAT_NOTFOUND;
								end else begin
									rk_q <= rd_key;
									rp_q <= rd_pay;
								end
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_UP: begin
					// Walk down from the tail to the target, moving each entry up.
					chk_q <= iss_q;
					idx_q <= ptr_q;
					if (iss_q) begin
						ptr_q <= ptr_q - CW'(1);
						iss_q <= (ptr_q != tgt_q);
					end
					if (chk_q && idx_q == tgt_q) begin
						chk_q   <= 1'b0;
						iss_q   <= 1'b0;
						state_q <= S_WRITE;
					end
				end

				S_DOWN: begin
					// Walk up from just past the removed entry, moving each one down.
					chk_q <= iss_q;
					idx_q <= ptr_q;
					if (iss_q) begin
						ptr_q <= ptr_q + CW'(1);
						iss_q <= (ptr_q != count_q - CW'(1));
					end
					if (chk_q && last_idx) begin
						chk_q   <= 1'b0;
						iss_q   <= 1'b0;
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end

				S_WRITE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end

				S_READ: begin
					// Present the address, then take the data once the RAM output holds it.
					chk_q <= 1'b1;
					if (chk_q) begin
						chk_q   <= 1'b0;
						rk_q    <= rd_key;
						rp_q    <= rd_pay;
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_W'({(count_q == '0), count_q, rp_q, rk_q, status_q});
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The entry count never passes the capacity.
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))

	// The RAM is written only by the shift walks and the final insert write.
	`ASSERT_IMPLIES(a_write_state, clk, arst_n, ram_we,
		state_q == S_UP || state_q == S_DOWN || state_q == S_WRITE)

	// A downward shift never writes below address zero.
	`ASSERT_IMPLIES(a_down_idx, clk, arst_n, state_q == S_DOWN && chk_q, idx_q != '0)

	// A result appears only after the sequencer finished an operation.
	`ASSERT_IMPLIES(a_result_src, clk, arst_n, $rose(m_tvalid_q), $past(state_q == S_DONE))

	// An insert that reaches the write step always has room.
	`ASSERT_IMPLIES(a_insert_room, clk, arst_n, state_q == S_WRITE, !full)

endmodule

[hw/rtl/ordl_ram.sv]
module ordl_ram #(
	parameter int WIDTH = ordl_pkg::KEY_WIDTH_DFLT + ordl_pkg::PAYLOAD_WIDTH_DFLT,
	parameter int DEPTH = ordl_pkg::CAPACITY_DFLT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
